// File: rtl/core/udp_port_filter_payload_checker_core_assert.svh
// ----------------------------------------------------------------------------
// udp port filter payload checker - assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef UDP_PORT_FILTER_PAYLOAD_CHECKER_CORE_ASSERT_SVH
`define UDP_PORT_FILTER_PAYLOAD_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// plain property check
`define UPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication check, antecedent then consequent in the same cycle
`define UPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication check, consequent in the cycle after
`define UPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UPC_ASSERT(lbl, prop, msg)
`define UPC_ASSERT_IMP(lbl, ante, cons, msg)
`define UPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/upc_pkg.sv
// ----------------------------------------------------------------------------
// upc_pkg
// types and fixed constants of the udp port filter payload checker
// ----------------------------------------------------------------------------
`default_nettype none

package upc_pkg;

    // frame layout
    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] IHL_OFFSET     = 16'd14;
    localparam logic [15:0] PROTO_OFFSET   = 16'd23;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [15:0] DPORT_OFFSET   = 16'd2;
    localparam logic [15:0] ULEN_OFFSET    = 16'd4;
    localparam logic [15:0] MIN_FRAME      = 16'd42;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] PORT_RESET     = 16'd9999;

    // malformation pair
    localparam logic [7:0]  PAT_FIRST      = 8'h45;
    localparam logic [7:0]  PAT_SECOND     = 8'h00;

    typedef enum logic [2:0] {
        V_SHORT      = 3'd0,
        V_NOT_UDP    = 3'd1,
        V_OTHER_PORT = 3'd2,
        V_BAD_LENGTH = 3'd3,
        V_MALFORMED  = 3'd4,
        V_GOOD       = 3'd5
    } verdict_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t  item_kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        within_length;
        verdict_t    verdict;
        logic [15:0] logged_length;
        logic [31:0] record_number;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic nonempty;
        logic room_for_two;
    } fifo_status_t;

endpackage

`default_nettype wire

// File: rtl/core/upc_in_if.sv
// ----------------------------------------------------------------------------
// upc_in_if
// frame byte channel
// ----------------------------------------------------------------------------
`default_nettype none

interface upc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/upc_out_if.sv
// ----------------------------------------------------------------------------
// upc_out_if
// result channel: payload bytes and end-of-frame verdicts
// ----------------------------------------------------------------------------
`default_nettype none

interface upc_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        within_length;
    logic [2:0]  verdict;
    logic [15:0] logged_length;
    logic [31:0] record_number;
    logic        last_of_run;

    modport source (
        output valid, output item_kind, output payload_byte, output payload_index,
        output within_length, output verdict, output logged_length,
        output record_number, output last_of_run, input ready
    );
    modport sink (
        input valid, input item_kind, input payload_byte, input payload_index,
        input within_length, input verdict, input logged_length,
        input record_number, input last_of_run, output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/upc_cfg_if.sv
// ----------------------------------------------------------------------------
// upc_cfg_if
// configuration write channel for the match port register
// ----------------------------------------------------------------------------
`default_nettype none

interface upc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/upc_result_fifo.sv
// ----------------------------------------------------------------------------
// upc_result_fifo
// four-entry result queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module upc_result_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            push_count,
    input  wire upc_pkg::result_t      push_first,
    input  wire upc_pkg::result_t      push_second,
    input  wire logic                  pop,
    output upc_pkg::result_t           head,
    output upc_pkg::fifo_status_t      status
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    upc_pkg::result_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push_count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            mem[wr_ptr_reg] <= push_first;
        if (push_count == 2'd2)
            mem[wr_ptr_plus1] <= push_second;
    end

    assign head                = mem[rd_ptr_reg];
    assign status.nonempty     = (count_reg != '0);
    assign status.room_for_two = (count_reg <= CW'(DEPTH - 2));

endmodule

`default_nettype wire

// File: rtl/core/udp_port_filter_payload_checker_core.sv
// ----------------------------------------------------------------------------
// udp_port_filter_payload_checker_core
// udp destination port filter with payload forwarding and pair scan
// ----------------------------------------------------------------------------
// Frame bytes enter on rx, one beat per byte, frame_end on the final byte.
// Each beat is latched in an input stage and handled once the buffer has room
// for two results: header fields are picked out by byte offset, payload bytes
// (offset H+8 and on) are forwarded as payload results, and the final beat
// also yields a verdict result. Results queue in a four-entry buffer ahead of
// tx, so one byte per cycle is sustained while tx keeps up; a final beat that
// is also a payload byte yields two results and costs one extra tx beat.
// rx.ready drops only when the input stage holds a beat and the buffer has
// fewer than two free entries. An rx beat passes through the input stage and
// the result buffer before its first tx beat. The match port is written
// through cfg, which is always ready; write only while the block is idle.
`default_nettype none
`include "udp_port_filter_payload_checker_core_assert.svh"

module udp_port_filter_payload_checker_core #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  wire logic clk,
    input  wire logic rst_n,
    upc_in_if.sink    rx,
    upc_out_if.source tx,
    upc_cfg_if.sink   cfg
);

    localparam logic [15:0] MAX_BYTES = 16'(MAX_FRAME_BYTES);

    // input stage
    logic       stg_valid_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_end_reg;
    logic       stg_fire;

    // configuration
    logic [15:0] match_port_reg;

    // per-frame state
    logic [15:0] byte_offset_reg,  byte_offset_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [7:0]  ip_protocol_reg,  ip_protocol_next;
    logic [15:0] seen_port_reg,    seen_port_next;
    logic [15:0] udp_length_reg,   udp_length_next;
    logic [7:0]  prev_byte_reg,    prev_byte_next;
    logic        prev_in_pay_reg,  prev_in_pay_next;
    logic        pattern_reg,      pattern_next;
    logic [31:0] record_counter_reg, record_counter_next;

    // result build
    upc_pkg::result_t      res_pay, res_ver, push_first, push_second, head;
    upc_pkg::fifo_status_t fifo_status;
    logic [1:0]            push_count;
    logic                  pay_hit;
    logic                  logged_frame;

    assign cfg.ready = 1'b1;
    assign stg_fire  = stg_valid_reg && fifo_status.room_for_two;
    assign rx.ready  = !stg_valid_reg || stg_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_port_reg <= upc_pkg::PORT_RESET;
        else if (cfg.valid)
            match_port_reg <= cfg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (rx.ready)
            stg_valid_reg <= rx.valid;
    end

    // payload of the input stage, no reset needed
    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            stg_byte_reg <= rx.frame_byte;
            stg_end_reg  <= rx.frame_end;
        end
    end

    // offset compares, field capture, pair scan and verdict
    always_comb
    begin
        logic [15:0] off;
        logic [15:0] hdr;
        logic [15:0] pay;
        logic [15:0] idx;
        logic [15:0] cap;
        logic        active;
        logic        in_len;
        upc_pkg::verdict_t vd;
        logic [15:0] logged;

        off    = byte_offset_reg;
        active = off < MAX_BYTES;
        in_len = 1'b0;
        idx    = '0;
        pay_hit = 1'b0;

        header_words_next = header_words_reg;
        ip_protocol_next  = ip_protocol_reg;
        seen_port_next    = seen_port_reg;
        udp_length_next   = udp_length_reg;
        prev_byte_next    = prev_byte_reg;
        prev_in_pay_next  = prev_in_pay_reg;
        pattern_next      = pattern_reg;
        byte_offset_next  = off;

        if (active && off == upc_pkg::IHL_OFFSET)
            header_words_next = stg_byte_reg[3:0];

        // header start of udp: 14 + 4 * ihl
        hdr = upc_pkg::ETH_HDR_BYTES + {10'd0, header_words_next, 2'b00};
        pay = hdr + upc_pkg::UDP_HDR_BYTES;

        if (active)
        begin
            if (off == upc_pkg::PROTO_OFFSET)
                ip_protocol_next = stg_byte_reg;
            if (off == hdr + upc_pkg::DPORT_OFFSET)
                seen_port_next[15:8] = stg_byte_reg;
            if (off == hdr + upc_pkg::DPORT_OFFSET + 16'd1)
                seen_port_next[7:0] = stg_byte_reg;
            if (off == hdr + upc_pkg::ULEN_OFFSET)
                udp_length_next[15:8] = stg_byte_reg;
            if (off == hdr + upc_pkg::ULEN_OFFSET + 16'd1)
                udp_length_next[7:0] = stg_byte_reg;
            if (off >= pay)
            begin
                pay_hit = 1'b1;
                idx     = off - pay;
                in_len  = (udp_length_next > upc_pkg::UDP_HDR_BYTES) &&
                          (idx < udp_length_next - upc_pkg::UDP_HDR_BYTES);
                if (in_len && prev_in_pay_reg && prev_byte_reg == upc_pkg::PAT_FIRST &&
                    stg_byte_reg == upc_pkg::PAT_SECOND)
                    pattern_next = 1'b1;
            end
            prev_in_pay_next = pay_hit;
            prev_byte_next   = stg_byte_reg;
            byte_offset_next = off + 16'd1;
        end

        // verdict on the closing beat
        cap          = byte_offset_next;
        logged       = '0;
        logged_frame = 1'b0;
        if (cap < upc_pkg::MIN_FRAME)
            vd = upc_pkg::V_SHORT;
        else if (ip_protocol_next != upc_pkg::PROTO_UDP)
            vd = upc_pkg::V_NOT_UDP;
        else if (cap < pay)
            vd = upc_pkg::V_SHORT;
        else if (seen_port_next != match_port_reg)
            vd = upc_pkg::V_OTHER_PORT;
        else
        begin
            logged_frame = 1'b1;
            if (udp_length_next <= upc_pkg::UDP_HDR_BYTES)
            begin
                vd     = upc_pkg::V_BAD_LENGTH;
                logged = cap - pay;
            end
            else
            begin
                vd     = pattern_next ? upc_pkg::V_MALFORMED : upc_pkg::V_GOOD;
                logged = udp_length_next - upc_pkg::UDP_HDR_BYTES;
            end
        end

        res_pay.item_kind     = upc_pkg::KIND_PAYLOAD;
        res_pay.payload_byte  = stg_byte_reg;
        res_pay.payload_index = idx;
        res_pay.within_length = in_len;
        res_pay.verdict       = upc_pkg::V_SHORT;
        res_pay.logged_length = '0;
        res_pay.record_number = '0;
        res_pay.last_of_run   = 1'b0;

        res_ver.item_kind     = upc_pkg::KIND_VERDICT;
        res_ver.payload_byte  = '0;
        res_ver.payload_index = '0;
        res_ver.within_length = 1'b0;
        res_ver.verdict       = vd;
        res_ver.logged_length = logged;
        res_ver.record_number = logged_frame ? record_counter_reg : 32'd0;
        res_ver.last_of_run   = 1'b1;

        record_counter_next = record_counter_reg;
        if (stg_end_reg)
        begin
            if (logged_frame)
                record_counter_next = record_counter_reg + 32'd1;
            // frame closed: clear per-frame state
            byte_offset_next  = '0;
            header_words_next = '0;
            ip_protocol_next  = '0;
            seen_port_next    = '0;
            udp_length_next   = '0;
            prev_byte_next    = '0;
            prev_in_pay_next  = 1'b0;
            pattern_next      = 1'b0;
        end

        // payload result goes ahead of the verdict
        push_first  = pay_hit ? res_pay : res_ver;
        push_second = res_ver;
        push_count  = stg_fire ? (2'(pay_hit) + 2'(stg_end_reg)) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg    <= '0;
            header_words_reg   <= '0;
            ip_protocol_reg    <= '0;
            seen_port_reg      <= '0;
            udp_length_reg     <= '0;
            prev_byte_reg      <= '0;
            prev_in_pay_reg    <= 1'b0;
            pattern_reg        <= 1'b0;
            record_counter_reg <= '0;
        end
        else if (stg_fire)
        begin
            byte_offset_reg    <= byte_offset_next;
            header_words_reg   <= header_words_next;
            ip_protocol_reg    <= ip_protocol_next;
            seen_port_reg      <= seen_port_next;
            udp_length_reg     <= udp_length_next;
            prev_byte_reg      <= prev_byte_next;
            prev_in_pay_reg    <= prev_in_pay_next;
            pattern_reg        <= pattern_next;
            record_counter_reg <= record_counter_next;
        end
    end

    // result queue decouples tx stalls from the byte stream
    upc_result_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push_first  (push_first),
        .push_second (push_second),
        .pop         (tx.valid && tx.ready),
        .head        (head),
        .status      (fifo_status)
    );

    assign tx.valid         = fifo_status.nonempty;
    assign tx.item_kind     = head.item_kind;
    assign tx.payload_byte  = head.payload_byte;
    assign tx.payload_index = head.payload_index;
    assign tx.within_length = head.within_length;
    assign tx.verdict       = head.verdict;
    assign tx.logged_length = head.logged_length;
    assign tx.record_number = head.record_number;
    assign tx.last_of_run   = head.last_of_run;

    // a beat is only taken on into the frame logic with room for both results
    `UPC_ASSERT_IMP(a_room, stg_fire, fifo_status.room_for_two, "stage fired without room")
    // closing beat leaves the per-frame state cleared
    `UPC_ASSERT_NEXT(a_clear, stg_fire && stg_end_reg,
        byte_offset_reg == 16'd0 && !pattern_reg, "frame state not cleared")
    // record counter moves by one per logged frame
    `UPC_ASSERT_NEXT(a_rec, stg_fire && stg_end_reg && logged_frame,
        record_counter_reg == $past(record_counter_reg) + 32'd1, "record counter slip")
    // offset never runs past the capture limit
    `UPC_ASSERT(a_off, byte_offset_reg <= MAX_BYTES, "byte offset beyond limit")

endmodule

`default_nettype wire

// File: tb/sv/upc_result_checker.sv
// ----------------------------------------------------------------------------
// upc_result_checker
// watches the rx, tx and cfg channels of the udp port filter, predicts every
// result from the accepted frame bytes and compares each tx beat in order
// ----------------------------------------------------------------------------
module upc_result_checker #(
    parameter int MAX_FRAME_BYTES = 65535
) (
    input  wire logic clk,
    input  wire logic rst_n,
    upc_in_if         rx_mon,
    upc_out_if        tx_mon,
    upc_cfg_if        cfg_mon,
    output int        mismatch_count,
    output int        outstanding,
    output int        results_checked,
    output int        frames_logged
);

    localparam int PRINT_CAP = 200;

    // predicted frame state
    logic [15:0] frame_offset;
    logic [3:0]  ihl_words;
    logic [7:0]  proto_seen;
    logic [15:0] dport_seen;
    logic [15:0] ulen_seen;
    logic [7:0]  last_byte;
    logic        last_was_payload;
    logic        pair_found;
    logic [31:0] next_record;
    logic [15:0] port_filter;

    upc_pkg::result_t expected_results[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                     results_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic clear_frame_state();
        frame_offset     = '0;
        ihl_words        = '0;
        proto_seen       = '0;
        dport_seen       = '0;
        ulen_seen        = '0;
        last_byte        = '0;
        last_was_payload = 1'b0;
        pair_found       = 1'b0;
    endtask

    task automatic predict_frame_byte(input logic [7:0] b, input logic fin);
        int               hdr;
        int               pay;
        int               idx;
        int               cap;
        logic             in_len;
        logic             in_pay;
        upc_pkg::result_t r;
        in_pay = 1'b0;
        if (int'(frame_offset) < MAX_FRAME_BYTES) begin
            if (frame_offset == upc_pkg::IHL_OFFSET)
                ihl_words = b[3:0];
            hdr = int'(upc_pkg::ETH_HDR_BYTES) + 4 * int'(ihl_words);
            pay = hdr + int'(upc_pkg::UDP_HDR_BYTES);
            if (frame_offset == upc_pkg::PROTO_OFFSET)
                proto_seen = b;
            // fields are picked independently, so overlaps simply overwrite
            if (int'(frame_offset) == hdr + int'(upc_pkg::DPORT_OFFSET))
                dport_seen[15:8] = b;
            if (int'(frame_offset) == hdr + int'(upc_pkg::DPORT_OFFSET) + 1)
                dport_seen[7:0] = b;
            if (int'(frame_offset) == hdr + int'(upc_pkg::ULEN_OFFSET))
                ulen_seen[15:8] = b;
            if (int'(frame_offset) == hdr + int'(upc_pkg::ULEN_OFFSET) + 1)
                ulen_seen[7:0] = b;
            if (int'(frame_offset) >= pay) begin
                idx    = int'(frame_offset) - pay;
                in_len = (int'(ulen_seen) > int'(upc_pkg::UDP_HDR_BYTES)) &&
                         (idx < int'(ulen_seen) - int'(upc_pkg::UDP_HDR_BYTES));
                r               = '0;
                r.item_kind     = upc_pkg::KIND_PAYLOAD;
                r.payload_byte  = b;
                r.payload_index = idx[15:0];
                r.within_length = in_len;
                r.verdict       = upc_pkg::V_SHORT;
                expected_results.insert(expected_results.size(), r);
                in_pay = 1'b1;
                if (in_len && last_was_payload && last_byte == upc_pkg::PAT_FIRST &&
                    b == upc_pkg::PAT_SECOND)
                    pair_found = 1'b1;
            end
            last_was_payload = in_pay;
            last_byte        = b;
            frame_offset     = frame_offset + 16'd1;
        end

        if (fin) begin
            cap           = int'(frame_offset);
            hdr           = int'(upc_pkg::ETH_HDR_BYTES) + 4 * int'(ihl_words);
            pay           = hdr + int'(upc_pkg::UDP_HDR_BYTES);
            r             = '0;
            r.item_kind   = upc_pkg::KIND_VERDICT;
            r.last_of_run = 1'b1;
            if (cap < int'(upc_pkg::MIN_FRAME))
                r.verdict = upc_pkg::V_SHORT;
            else if (proto_seen != upc_pkg::PROTO_UDP)
                r.verdict = upc_pkg::V_NOT_UDP;
            else if (cap < pay)
                r.verdict = upc_pkg::V_SHORT;
            else if (dport_seen != port_filter)
                r.verdict = upc_pkg::V_OTHER_PORT;
            else begin
                if (int'(ulen_seen) <= int'(upc_pkg::UDP_HDR_BYTES)) begin
                    r.verdict       = upc_pkg::V_BAD_LENGTH;
                    r.logged_length = 16'(cap - pay);
                end
                else begin
                    r.verdict       = pair_found ? upc_pkg::V_MALFORMED : upc_pkg::V_GOOD;
                    r.logged_length = ulen_seen - upc_pkg::UDP_HDR_BYTES;
                end
                r.record_number = next_record;
                next_record     = next_record + 32'd1;
                frames_logged++;
            end
            expected_results.insert(expected_results.size(), r);
            clear_frame_state();
        end
    endtask

    task automatic check_result();
        upc_pkg::result_t want;
        if (expected_results.size() == 0)
            report_mismatch("unexpected result, kind", 32'(tx_mon.item_kind), 32'd0);
        else begin
            want = expected_results.pop_front();
            if (tx_mon.item_kind !== want.item_kind)
                report_mismatch("item_kind", 32'(tx_mon.item_kind), 32'(want.item_kind));
            if (tx_mon.payload_byte !== want.payload_byte)
                report_mismatch("payload_byte", 32'(tx_mon.payload_byte),
                                32'(want.payload_byte));
            if (tx_mon.payload_index !== want.payload_index)
                report_mismatch("payload_index", 32'(tx_mon.payload_index),
                                32'(want.payload_index));
            if (tx_mon.within_length !== want.within_length)
                report_mismatch("within_length", 32'(tx_mon.within_length),
                                32'(want.within_length));
            if (tx_mon.verdict !== want.verdict)
                report_mismatch("verdict", 32'(tx_mon.verdict), 32'(want.verdict));
            if (tx_mon.logged_length !== want.logged_length)
                report_mismatch("logged_length", 32'(tx_mon.logged_length),
                                32'(want.logged_length));
            if (tx_mon.record_number !== want.record_number)
                report_mismatch("record_number", tx_mon.record_number, want.record_number);
            if (tx_mon.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", 32'(tx_mon.last_of_run),
                                32'(want.last_of_run));
        end
        results_checked++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_frame_state();
            next_record     = '0;
            port_filter     = upc_pkg::PORT_RESET;
            expected_results.delete();
            mismatch_count  = 0;
            outstanding     = 0;
            results_checked = 0;
            frames_logged   = 0;
        end
        else begin
            if (cfg_mon.valid && cfg_mon.ready)
                port_filter = cfg_mon.data;
            if (tx_mon.valid && tx_mon.ready)
                check_result();
            if (rx_mon.valid && rx_mon.ready)
                predict_frame_byte(rx_mon.frame_byte, rx_mon.frame_end);
            outstanding = expected_results.size();
        end
    end

endmodule

// File: tb/sv/tb_udp_port_filter_payload_checker_core.sv
// ----------------------------------------------------------------------------
// tb_udp_port_filter_payload_checker_core
// drives frames byte by byte into the udp port filter, stalls both channels
// in random bursts and leaves prediction and comparison to the checker
// ----------------------------------------------------------------------------
module tb_udp_port_filter_payload_checker_core;

    localparam int  MAX_FRAME_BYTES = 65535;
    localparam int  SEGMENTS        = 2;
    localparam int  SEGMENT_BYTES   = 50;
    localparam int  SEGMENT_FRAMES  = 1;
    localparam int  SETTLE_CYCLES   = 8;
    // run limit, far beyond the slowest correct run
    localparam time RUN_LIMIT       = 64'd20_000_000;

    typedef logic [7:0] frame_bytes_t[$];

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic idle_on = 1'b1;

    int mismatch_count;
    int results_pending;
    int results_checked;
    int frames_logged;

    int frames_sent = 0;
    int bytes_sent  = 0;
    int port_writes = 0;
    int current_port;

    upc_in_if  in_ch ();
    upc_out_if out_ch ();
    upc_cfg_if cfg_ch ();

    udp_port_filter_payload_checker_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (in_ch),
        .tx    (out_ch),
        .cfg   (cfg_ch)
    );

    upc_result_checker #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_mon          (in_ch),
        .tx_mon          (out_ch),
        .cfg_mon         (cfg_ch),
        .mismatch_count  (mismatch_count),
        .outstanding     (results_pending),
        .results_checked (results_checked),
        .frames_logged   (frames_logged)
    );

    always #10 clk = ~clk;

    // safety net in case the block hangs
    initial
    begin
        #(RUN_LIMIT);
        $display("udp_port_filter_payload_checker_core verification failed");
        $finish;
    end

    // tx side: ready drops in random bursts while idling is on
    initial
    begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left   = $urandom_range(1, 19) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // one rx beat, optionally preceded by a burst of idle cycles
    task automatic push_byte(input logic [7:0] b, input logic fin);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 11) == 0)
        begin
            gap          = $urandom_range(1, 19);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.frame_byte <= b;
        in_ch.frame_end  <= fin;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    // valid is left high after the last beat of a frame, so back-to-back
    // frames stream without a bubble; anything that waits must drop it first
    task automatic send_frame(input frame_bytes_t f);
        int i;
        for (i = 0; i < f.size(); i++)
            push_byte(f[i], i == f.size() - 1);
        frames_sent++;
    endtask

    // hold off until every predicted result has come out, plus a little slack
    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // match port write, only ever with the block idle
    task automatic set_match_port(input int value);
        drain_results();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= 16'(value);
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        current_port = value;
        port_writes++;
    endtask

    function automatic frame_bytes_t filled_frame(input int len, input logic [7:0] value);
        frame_bytes_t q;
        repeat (len) q.insert(q.size(), value);
        return q;
    endfunction

    // ethernet + ip + udp frame with random filler; pairs drop 0x45 0x00
    // somewhere into the payload
    function automatic frame_bytes_t build_udp_frame(input int ihl, input int proto,
                                                     input int dport, input int ulen,
                                                     input int payload_len, input int pairs);
        frame_bytes_t q;
        int hdr;
        int total;
        int pos;
        hdr   = 14 + 4 * ihl;
        total = hdr + 8 + payload_len;
        repeat (total) q.insert(q.size(), 8'($urandom));
        q[14] = {4'($urandom), 4'(ihl)};
        if (total > 23)
            q[23] = 8'(proto);
        // later writes win, which is how small header lengths overlap
        q[hdr + 2] = 8'(dport >> 8);
        q[hdr + 3] = 8'(dport);
        q[hdr + 4] = 8'(ulen >> 8);
        q[hdr + 5] = 8'(ulen);
        if (payload_len >= 2)
            repeat (pairs)
            begin
                pos        = $urandom_range(hdr + 8, total - 2);
                q[pos]     = upc_pkg::PAT_FIRST;
                q[pos + 1] = upc_pkg::PAT_SECOND;
            end
        return q;
    endfunction

    // mostly well-formed frames aimed at the current port, the rest cut short,
    // carrying another protocol, or plain noise
    task automatic send_random_frame();
        frame_bytes_t f;
        int pick;
        int ihl;
        int proto;
        int dport;
        int ulen;
        int plen;
        int pairs;
        int cut;
        pick  = $urandom_range(0, 99);
        ihl   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
        proto = int'(upc_pkg::PROTO_UDP);
        dport = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535) : current_port;
        plen  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
        case ($urandom_range(0, 9))
            0:       ulen = $urandom_range(0, 8);
            1:       ulen = $urandom_range(0, 65535);
            2:       ulen = plen + 8 + $urandom_range(1, 4);
            3:       ulen = (plen >= 4) ? plen + 8 - $urandom_range(1, 4) : plen + 8;
            default: ulen = plen + 8;
        endcase
        pairs = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        if (pick >= 85)
        begin
            repeat ($urandom_range(1, 70)) f.insert(f.size(), 8'($urandom));
        end
        else
        begin
            if (pick >= 75)
            begin
                proto = $urandom_range(0, 255);
                if (proto == int'(upc_pkg::PROTO_UDP))
                    proto = 6;
            end
            f = build_udp_frame(ihl, proto, dport, ulen, plen, pairs);
            if (pick >= 60 && pick < 75)
            begin
                cut = $urandom_range(1, f.size());
                while (f.size() > cut) f.delete(f.size() - 1);
            end
        end
        send_frame(f);
    endtask

    initial
    begin
        frame_bytes_t f;
        int           seg;
        int           seg_bytes;
        int           seg_frames;
        int           p;

        in_ch.valid      = 1'b0;
        in_ch.frame_byte = '0;
        in_ch.frame_end  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        current_port     = int'(upc_pkg::PORT_RESET);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed frames, match port still at its reset value ----
        p = int'(upc_pkg::PORT_RESET);
        // single byte frame, end flag on the very first beat
        f = '{8'h00};
        send_frame(f);
        // one byte below the minimum frame length
        send_frame(filled_frame(41, 8'hff));
        // plain good frame
        send_frame(build_udp_frame(5, 17, p, 12, 4, 0));
        // exactly 42 bytes with a udp length of 8: bad length, logged length zero
        send_frame(build_udp_frame(5, 17, p, 8, 0, 0));
        // udp length below the header size with payload present
        send_frame(build_udp_frame(5, 17, p, 3, 5, 0));
        // pair inside the payload
        send_frame(build_udp_frame(5, 17, p, 18, 10, 1));
        // pair straddling header and payload does not count
        f = build_udp_frame(5, 17, p, 14, 6, 0);
        f[41] = upc_pkg::PAT_FIRST;
        f[42] = upc_pkg::PAT_SECOND;
        send_frame(f);
        // pair whose second byte sits exactly at the udp length limit
        f = build_udp_frame(5, 17, p, 12, 8, 0);
        f[45] = upc_pkg::PAT_FIRST;
        f[46] = upc_pkg::PAT_SECOND;
        send_frame(f);
        // same pair one byte earlier, fully inside the length
        f = build_udp_frame(5, 17, p, 12, 8, 0);
        f[44] = upc_pkg::PAT_FIRST;
        f[45] = upc_pkg::PAT_SECOND;
        send_frame(f);
        // tcp frame
        send_frame(build_udp_frame(5, 6, p, 12, 4, 0));
        // largest ip header, cut before the payload starts
        f = build_udp_frame(15, 17, p, 16, 8, 0);
        while (f.size() > 60) f.delete(f.size() - 1);
        send_frame(f);
        // zero header length: protocol byte lands in the payload
        f = build_udp_frame(0, 17, p, 36, 28, 0);
        f[23] = upc_pkg::PROTO_UDP;
        send_frame(f);
        // header length 1: udp length low byte doubles as the protocol byte
        send_frame(build_udp_frame(1, 17, p, 17, 16, 1));
        // wrong port
        send_frame(build_udp_frame(5, 17, p ^ 1, 12, 4, 0));
        // all-zero and all-ones frames
        send_frame(filled_frame(60, 8'h00));
        send_frame(filled_frame(60, 8'hff));
        // udp length far beyond what was captured
        send_frame(build_udp_frame(5, 17, p, 65535, 6, 0));

        // ---- extremes of the match port ----
        set_match_port(0);
        send_frame(build_udp_frame(5, 17, 0, 20, 12, 1));
        send_frame(build_udp_frame(5, 17, 65535, 20, 12, 0));
        set_match_port(65535);
        send_frame(build_udp_frame(5, 17, 65535, 0, 3, 0));
        send_frame(build_udp_frame(5, 17, 65535, 20, 12, 1));
        send_frame(build_udp_frame(5, 17, 0, 20, 12, 0));

        // ---- random segments, each under a fresh match port ----
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            set_match_port($urandom_range(0, 65535));
            if (seg == SEGMENTS - 1)
            begin
                // the closing stretch runs with both sides streaming
                @(posedge clk);
                idle_on = 1'b0;
            end
            seg_bytes  = bytes_sent;
            seg_frames = 0;
            while (bytes_sent - seg_bytes < SEGMENT_BYTES || seg_frames < SEGMENT_FRAMES)
            begin
                send_random_frame();
                seg_frames++;
                // now and then the sender waits for the block to empty out
                if ($urandom_range(0, 9) == 0)
                    drain_results();
            end
        end

        // ---- wind down ----
        drain_results();
        repeat (20) @(negedge clk);

        $display("sent %0d frames (%0d bytes) under %0d match port writes",
                 frames_sent, bytes_sent, port_writes);
        $display("checked %0d results, %0d frames logged", results_checked, frames_logged);
        if (mismatch_count == 0)
            $display("udp_port_filter_payload_checker_core verification clean");
        else
            $display("udp_port_filter_payload_checker_core verification failed");
        $finish;
    end

endmodule
